// ===== hw/rtl/ffpa_pkg.sv =====
`default_nettype none

package ffpa_pkg;

   // Stream payload layout
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned BYTES_W     = 13;
   localparam int unsigned OFFSET_W    = 12;

   // Request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      DP_NOP,
      DP_CLEAR,
      DP_ACCEPT,
      DP_RD_CUR,
      DP_ADVANCE,
      DP_WR_SPLIT_N,
      DP_WR_SPLIT_CUR,
      DP_LINK_N,
      DP_UNLINK,
      DP_RD_H,
      DP_FREE_EMPTY,
      DP_TAKE_H,
      DP_FREE_STEP,
      DP_WR_BOTH,
      DP_WR_JPREV,
      DP_WR_JNEXT,
      DP_WR_NONE,
      DP_LINK_H
   } dp_op_type;

   // Kind of response loaded into the output register
   typedef enum logic [1:0] {
      RSP_FAIL,
      RSP_ALLOC_OK,
      RSP_FREE_OK
   } rsp_kind_type;

   typedef struct packed {
      dp_op_type    op;
      logic         rsp_load;
      rsp_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_is_free;
      logic need_bad;
      logic alloc_stop;
      logic fit_split;
      logic fit_whole;
      logic hdr_last;
      logic free_bad;
      logic empty;
      logic free_more;
      logic free_dup;
      logic join_prev;
      logic join_next;
   } dp_status_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_TEST,
      ST_A_EVAL,
      ST_A_SPLIT_N,
      ST_A_SPLIT_CUR,
      ST_A_SPLIT_LINK,
      ST_A_WHOLE,
      ST_F_TEST,
      ST_F_HDR,
      ST_F_WALK,
      ST_F_MERGE,
      ST_F_LINK,
      ST_R_ALLOC,
      ST_R_OK,
      ST_R_FAIL
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ffpa_dpath.sv =====
`default_nettype none

module ffpa_dpath #(
   parameter int unsigned POOL_BYTES    = 4096,
   parameter int unsigned GRANULE_BYTES = 8,
   parameter int unsigned HEADER_BYTES  = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [ffpa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire ffpa_pkg::dp_cmd_type              cmd,
   output ffpa_pkg::dp_status_type                status,
   output logic      [ffpa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int unsigned AW  = $clog2(POOL_BYTES);
   localparam int unsigned SW  = $clog2(POOL_BYTES + 1);
   localparam int unsigned CW  = (SW + 2 > 15) ? SW + 2 : 15;
   localparam int unsigned GSH = $clog2(GRANULE_BYTES);
   localparam logic [CW-1:0] POOL_C  = CW'(POOL_BYTES);
   localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] LIMIT_C = CW'(POOL_BYTES - HEADER_BYTES);
   localparam logic [CW-1:0] GMASK_C = CW'(GRANULE_BYTES - 1);

   typedef struct packed {
      logic [SW-1:0] size;
      logic [AW-1:0] next;
      logic          last;
   } hdr_type;

   localparam hdr_type INIT_HDR = '{size: SW'(POOL_BYTES - HEADER_BYTES), next: '0, last: 1'b1};

   // Header store
   hdr_type mem [POOL_BYTES];

   hdr_type          rd_ff, prev_hdr_ff;
   logic [AW-1:0]    clr_idx_ff, clr_idx_in;
   logic [AW-1:0]    head_ff, head_in;
   logic             empty_ff, empty_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    prev_ff, prev_in;
   hdr_type          prev_hdr_in;
   logic [CW-1:0]    need_ff, need_in;
   logic [CW-1:0]    h_ff, h_in;
   logic [CW-1:0]    sz_ff, sz_in;
   logic [SW-1:0]    steps_ff, steps_in;
   logic             has_prev_ff, has_prev_in;
   logic             has_cur_ff, has_cur_in;
   logic             op_ff, op_in;
   logic [ffpa_pkg::RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic             we_c, re_c;
   logic [AW-1:0]    wa_c, ra_c;
   hdr_type          wd_c;

   logic [CW-1:0]    b_size_c, cur_c, prev_c, prev_size_c, split_n_c;
   logic [CW-1:0]    req_bytes_c, off_c;
   logic             inside_c;

   // Widened views of stored values
   always_comb begin
      b_size_c    = CW'(rd_ff.size);
      cur_c       = CW'(cur_ff);
      prev_c      = CW'(prev_ff);
      prev_size_c = CW'(prev_hdr_ff.size);
      split_n_c   = cur_c + HDR_C + need_ff;
      req_bytes_c = CW'(req_tdata[ffpa_pkg::BYTES_W:1]);
      off_c       = CW'(req_tdata[ffpa_pkg::BYTES_W+ffpa_pkg::OFFSET_W:ffpa_pkg::BYTES_W+1]);
      inside_c    = (b_size_c <= POOL_C) && (cur_c + HDR_C + b_size_c <= POOL_C);
   end

   // Status toward the controller
   always_comb begin
      status.clear_last  = (clr_idx_ff == AW'(POOL_BYTES - 1));
      status.req_is_free = (req_tdata[0] == ffpa_pkg::OP_FREE);
      status.need_bad    = (need_ff > LIMIT_C) || empty_ff;
      status.alloc_stop  = (CW'(steps_ff) >= POOL_C) || (cur_c >= POOL_C);
      status.fit_split   = inside_c && (b_size_c >= HDR_C + need_ff);
      status.fit_whole   = inside_c && (b_size_c >= need_ff);
      status.hdr_last    = rd_ff.last;
      status.free_bad    = (op_ff == ffpa_pkg::OP_FREE) && ((h_ff >= POOL_C) || (h_ff[CW-1]));
      status.empty       = empty_ff;
      status.free_more   = (CW'(steps_ff) < POOL_C) && (cur_c < h_ff);
      status.free_dup    = has_cur_ff && (cur_c == h_ff);
      status.join_prev   = has_prev_ff && (prev_c + HDR_C + prev_size_c == h_ff);
      status.join_next   = has_cur_ff && (h_ff + HDR_C + sz_ff == cur_c);
   end

   // Register updates and memory port control per operation
   always_comb begin
      clr_idx_in  = clr_idx_ff;
      head_in     = head_ff;
      empty_in    = empty_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      prev_hdr_in = prev_hdr_ff;
      need_in     = need_ff;
      h_in        = h_ff;
      sz_in       = sz_ff;
      steps_in    = steps_ff;
      has_prev_in = has_prev_ff;
      has_cur_in  = has_cur_ff;
      op_in       = op_ff;
      we_c        = 1'b0;
      wa_c        = '0;
      wd_c        = '0;
      re_c        = 1'b0;
      ra_c        = cur_ff;
      unique case (cmd.op)
         ffpa_pkg::DP_CLEAR: begin
            we_c       = 1'b1;
            wa_c       = clr_idx_ff;
            wd_c       = (clr_idx_ff == '0) ? INIT_HDR : '0;
            clr_idx_in = clr_idx_ff + AW'(1);
         end
         ffpa_pkg::DP_ACCEPT: begin
            op_in       = req_tdata[0];
            need_in     = ((req_bytes_c + GMASK_C) >> GSH) << GSH;
            // an offset below the header size sets the top bit and flags out of range
            h_in        = (off_c < HDR_C) ? {1'b1, {(CW-1){1'b0}}} : off_c - HDR_C;
            cur_in      = head_ff;
            steps_in    = '0;
            has_prev_in = 1'b0;
            has_cur_in  = 1'b1;
         end
         ffpa_pkg::DP_RD_CUR: begin
            re_c = 1'b1;
            ra_c = cur_ff;
         end
         ffpa_pkg::DP_ADVANCE: begin
            has_prev_in = 1'b1;
            prev_in     = cur_ff;
            prev_hdr_in = rd_ff;
            cur_in      = rd_ff.next;
            steps_in    = steps_ff + SW'(1);
         end
         ffpa_pkg::DP_WR_SPLIT_N: begin
            we_c = 1'b1;
            wa_c = AW'(split_n_c);
            wd_c = '{size: SW'(b_size_c - need_ff - HDR_C), next: rd_ff.next, last: rd_ff.last};
         end
         ffpa_pkg::DP_WR_SPLIT_CUR: begin
            we_c = 1'b1;
            wa_c = cur_ff;
            wd_c = '{size: SW'(need_ff), next: rd_ff.next, last: rd_ff.last};
         end
         ffpa_pkg::DP_LINK_N: begin
            if (has_prev_ff) begin
               we_c = 1'b1;
               wa_c = prev_ff;
               wd_c = '{size: prev_hdr_ff.size, next: AW'(split_n_c), last: 1'b0};
            end else begin
               head_in = AW'(split_n_c);
            end
         end
         ffpa_pkg::DP_UNLINK: begin
            priority if (has_prev_ff) begin
               we_c = 1'b1;
               wa_c = prev_ff;
               wd_c = '{size: prev_hdr_ff.size, next: rd_ff.next, last: rd_ff.last};
            end else if (rd_ff.last) begin
               empty_in = 1'b1;
            end else begin
               head_in = rd_ff.next;
            end
         end
         ffpa_pkg::DP_RD_H: begin
            re_c = 1'b1;
            ra_c = AW'(h_ff);
         end
         ffpa_pkg::DP_FREE_EMPTY: begin
            we_c     = 1'b1;
            wa_c     = AW'(h_ff);
            wd_c     = '{size: rd_ff.size, next: rd_ff.next, last: 1'b1};
            head_in  = AW'(h_ff);
            empty_in = 1'b0;
         end
         ffpa_pkg::DP_TAKE_H: begin
            sz_in = b_size_c;
            re_c  = 1'b1;
            ra_c  = cur_ff;
         end
         ffpa_pkg::DP_FREE_STEP: begin
            has_prev_in = 1'b1;
            prev_in     = cur_ff;
            prev_hdr_in = rd_ff;
            if (rd_ff.last) begin
               has_cur_in = 1'b0;
            end else begin
               cur_in   = rd_ff.next;
               steps_in = steps_ff + SW'(1);
               re_c     = 1'b1;
               ra_c     = rd_ff.next;
            end
         end
         ffpa_pkg::DP_WR_BOTH: begin
            we_c = 1'b1;
            wa_c = prev_ff;
            wd_c = '{size: SW'(prev_size_c + HDR_C + HDR_C + sz_ff + b_size_c),
                     next: rd_ff.next, last: rd_ff.last};
         end
         ffpa_pkg::DP_WR_JPREV: begin
            we_c = 1'b1;
            wa_c = prev_ff;
            wd_c = '{size: SW'(prev_size_c + HDR_C + sz_ff),
                     next: prev_hdr_ff.next, last: prev_hdr_ff.last};
         end
         ffpa_pkg::DP_WR_JNEXT: begin
            we_c = 1'b1;
            wa_c = AW'(h_ff);
            wd_c = '{size: SW'(sz_ff + HDR_C + b_size_c), next: rd_ff.next, last: rd_ff.last};
         end
         ffpa_pkg::DP_WR_NONE: begin
            we_c = 1'b1;
            wa_c = AW'(h_ff);
            wd_c = '{size: SW'(sz_ff), next: has_cur_ff ? cur_ff : '0, last: !has_cur_ff};
         end
         ffpa_pkg::DP_LINK_H: begin
            if (has_prev_ff) begin
               we_c = 1'b1;
               wa_c = prev_ff;
               wd_c = '{size: prev_hdr_ff.size, next: AW'(h_ff), last: 1'b0};
            end else begin
               head_in = AW'(h_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Build the response word: payload offset, then success
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         unique case (cmd.kind)
            ffpa_pkg::RSP_ALLOC_OK:
               rsp_in = {3'b000, 1'b1, ffpa_pkg::OFFSET_W'(cur_c + HDR_C)};
            ffpa_pkg::RSP_FREE_OK:
               rsp_in = {3'b000, 1'b1, {ffpa_pkg::OFFSET_W{1'b0}}};
            default:
               rsp_in = '0;
         endcase
      end
   end

   assign rsp_tdata = rsp_ff;

   // Header store ports
   always_ff @(posedge clock) begin
      if (we_c) begin
         mem[wa_c] <= wd_c;
      end
      if (re_c) begin
         rd_ff <= mem[ra_c];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         head_ff    <= '0;
         empty_ff   <= 1'b0;
      end else begin
         clr_idx_ff <= clr_idx_in;
         head_ff    <= head_in;
         empty_ff   <= empty_in;
      end
   end

   // Walk and payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_hdr_ff <= prev_hdr_in;
      need_ff     <= need_in;
      h_ff        <= h_in;
      sz_ff       <= sz_in;
      steps_ff    <= steps_in;
      has_prev_ff <= has_prev_in;
      has_cur_ff  <= has_cur_in;
      op_ff       <= op_in;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ffpa_ctrl.sv =====
`default_nettype none

module ffpa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire ffpa_pkg::dp_status_type status,
   output ffpa_pkg::dp_cmd_type         cmd
);

   ffpa_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free_c;

   assign slot_free_c = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ffpa_pkg::ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffpa_pkg::ST_CLEAR:
            if (status.clear_last) state_in = ffpa_pkg::ST_IDLE;
         ffpa_pkg::ST_IDLE:
            if (req_tvalid) begin
               state_in = status.req_is_free ? ffpa_pkg::ST_F_TEST : ffpa_pkg::ST_A_TEST;
            end
         ffpa_pkg::ST_A_TEST:
            state_in = (status.need_bad || status.alloc_stop) ? ffpa_pkg::ST_R_FAIL
                                                              : ffpa_pkg::ST_A_EVAL;
         ffpa_pkg::ST_A_EVAL: begin
            priority if (status.fit_split) state_in = ffpa_pkg::ST_A_SPLIT_N;
            else if (status.fit_whole)     state_in = ffpa_pkg::ST_A_WHOLE;
            else if (status.hdr_last)      state_in = ffpa_pkg::ST_R_FAIL;
            else                           state_in = ffpa_pkg::ST_A_TEST;
         end
         ffpa_pkg::ST_A_SPLIT_N:    state_in = ffpa_pkg::ST_A_SPLIT_CUR;
         ffpa_pkg::ST_A_SPLIT_CUR:  state_in = ffpa_pkg::ST_A_SPLIT_LINK;
         ffpa_pkg::ST_A_SPLIT_LINK: state_in = ffpa_pkg::ST_R_ALLOC;
         ffpa_pkg::ST_A_WHOLE:      state_in = ffpa_pkg::ST_R_ALLOC;
         ffpa_pkg::ST_F_TEST:
            state_in = status.free_bad ? ffpa_pkg::ST_R_FAIL : ffpa_pkg::ST_F_HDR;
         ffpa_pkg::ST_F_HDR:
            state_in = status.empty ? ffpa_pkg::ST_R_OK : ffpa_pkg::ST_F_WALK;
         ffpa_pkg::ST_F_WALK:
            if (!status.free_more || status.hdr_last) state_in = ffpa_pkg::ST_F_MERGE;
         ffpa_pkg::ST_F_MERGE: begin
            priority if (status.free_dup)                      state_in = ffpa_pkg::ST_R_OK;
            else if (status.join_prev)                         state_in = ffpa_pkg::ST_R_OK;
            else                                               state_in = ffpa_pkg::ST_F_LINK;
         end
         ffpa_pkg::ST_F_LINK: state_in = ffpa_pkg::ST_R_OK;
         ffpa_pkg::ST_R_ALLOC, ffpa_pkg::ST_R_OK, ffpa_pkg::ST_R_FAIL:
            if (slot_free_c) state_in = ffpa_pkg::ST_IDLE;
         default: state_in = ffpa_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd.op       = ffpa_pkg::DP_NOP;
      cmd.rsp_load = 1'b0;
      cmd.kind     = ffpa_pkg::RSP_FAIL;
      unique case (state_ff)
         ffpa_pkg::ST_CLEAR: cmd.op = ffpa_pkg::DP_CLEAR;
         ffpa_pkg::ST_IDLE:
            if (req_tvalid) cmd.op = ffpa_pkg::DP_ACCEPT;
         ffpa_pkg::ST_A_TEST:
            if (!(status.need_bad || status.alloc_stop)) cmd.op = ffpa_pkg::DP_RD_CUR;
         ffpa_pkg::ST_A_EVAL:
            if (!status.fit_split && !status.fit_whole && !status.hdr_last) begin
               cmd.op = ffpa_pkg::DP_ADVANCE;
            end
         ffpa_pkg::ST_A_SPLIT_N:    cmd.op = ffpa_pkg::DP_WR_SPLIT_N;
         ffpa_pkg::ST_A_SPLIT_CUR:  cmd.op = ffpa_pkg::DP_WR_SPLIT_CUR;
         ffpa_pkg::ST_A_SPLIT_LINK: cmd.op = ffpa_pkg::DP_LINK_N;
         ffpa_pkg::ST_A_WHOLE:      cmd.op = ffpa_pkg::DP_UNLINK;
         ffpa_pkg::ST_F_TEST:
            if (!status.free_bad) cmd.op = ffpa_pkg::DP_RD_H;
         ffpa_pkg::ST_F_HDR:
            cmd.op = status.empty ? ffpa_pkg::DP_FREE_EMPTY : ffpa_pkg::DP_TAKE_H;
         ffpa_pkg::ST_F_WALK:
            if (status.free_more) cmd.op = ffpa_pkg::DP_FREE_STEP;
         ffpa_pkg::ST_F_MERGE: begin
            priority if (status.free_dup)                     cmd.op = ffpa_pkg::DP_NOP;
            else if (status.join_prev && status.join_next)    cmd.op = ffpa_pkg::DP_WR_BOTH;
            else if (status.join_prev)                        cmd.op = ffpa_pkg::DP_WR_JPREV;
            else if (status.join_next)                        cmd.op = ffpa_pkg::DP_WR_JNEXT;
            else                                              cmd.op = ffpa_pkg::DP_WR_NONE;
         end
         ffpa_pkg::ST_F_LINK: cmd.op = ffpa_pkg::DP_LINK_H;
         ffpa_pkg::ST_R_ALLOC: begin
            cmd.rsp_load = slot_free_c;
            cmd.kind     = ffpa_pkg::RSP_ALLOC_OK;
         end
         ffpa_pkg::ST_R_OK: begin
            cmd.rsp_load = slot_free_c;
            cmd.kind     = ffpa_pkg::RSP_FREE_OK;
         end
         ffpa_pkg::ST_R_FAIL: begin
            cmd.rsp_load = slot_free_c;
            cmd.kind     = ffpa_pkg::RSP_FAIL;
         end
         default: begin
         end
      endcase
   end

   // Output valid: set on load, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffpa_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_pool_allocator_core.sv =====
// Allocate walks the free list one block at a time, then splits the block, hands it
//   out whole or fails; an oversized request or an empty list fails before any walk.
//   Free walks the free blocks below the freed one; an out-of-range free fails first.
// Requests: one at a time; the free-list walk through the single-read header
//   memory sets the rate.
// Reset: synchronous; a clearing pass then writes every header.
`default_nettype none

module first_fit_pool_allocator_core #(
   parameter int unsigned POOL_BYTES    = 4096,
   parameter int unsigned GRANULE_BYTES = 8,
   parameter int unsigned HEADER_BYTES  = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [0] operation, [13:1] request_bytes, [25:14] block_offset
   input  wire logic [ffpa_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [11:0] payload_offset, [12] success
   output logic      [ffpa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   ffpa_pkg::dp_cmd_type    cmd;
   ffpa_pkg::dp_status_type status;

   ffpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ffpa_dpath #(
      .POOL_BYTES    (POOL_BYTES),
      .GRANULE_BYTES (GRANULE_BYTES),
      .HEADER_BYTES  (HEADER_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ffpa_checker.sv =====
`default_nettype none

module ffpa_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [ffpa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // A stalled response keeps its data
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // A failed request reports a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[12] |-> rsp_tdata[11:0] == '0)
      else $error("failure with nonzero offset");

   // The block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind first_fit_pool_allocator_core ffpa_checker u_ffpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== dv/first_fit_pool_allocator_core_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

module first_fit_pool_allocator_core_test;

   localparam int unsigned POOL     = 4096;
   localparam int unsigned GRANULE  = 8;
   localparam int unsigned HDR      = 12;
   localparam int unsigned STALL_PCT = 12;
   localparam int unsigned WATCHDOG_LIMIT = 40000;
   localparam int unsigned RANDOM_ITEMS   = 1700;

   typedef struct {
      logic [ffpa_pkg::OFFSET_W-1:0] payload_offset;
      logic                          success;
   } alloc_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ffpa_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ffpa_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow of the pool headers and free list
   int unsigned   blk_size [POOL];
   int unsigned   blk_next [POOL];
   bit            blk_last [POOL];
   int unsigned   list_head;
   bit            list_empty;

   alloc_result_type pending_results[$];
   int unsigned   live_offsets[$];
   int unsigned   error_count = 0;
   int unsigned   quiet_cycles = 0;
   bit            no_idle = 1'b0;
   int unsigned   hold_off_request = 0;
   int unsigned   accept_count = 0;

   first_fit_pool_allocator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Point the previous free block, or the list head, at a header
   function automatic void link_to(bit has_prev, int unsigned prev, int unsigned target);
      if (has_prev) begin
         blk_next[prev] = target;
         blk_last[prev] = 1'b0;
      end else begin
         list_head = target;
      end
   endfunction

   function automatic void pool_reset();
      for (int i = 0; i < POOL; i++) begin
         blk_size[i] = 0;
         blk_next[i] = 0;
         blk_last[i] = 1'b0;
      end
      blk_size[0] = POOL - HDR;
      blk_last[0] = 1'b1;
      list_head   = 0;
      list_empty  = 1'b0;
   endfunction

   // First-fit search with split or whole hand-out
   function automatic int unsigned first_fit(int unsigned req, output bit ok);
      int unsigned need;
      int unsigned cur;
      int unsigned prev;
      int unsigned n;
      bit          has_prev;
      bit          in_pool;
      need     = (req + GRANULE - 1) / GRANULE * GRANULE;
      prev     = 0;
      has_prev = 1'b0;
      ok       = 1'b0;
      if (need > POOL - HDR || list_empty) return 0;
      cur = list_head;
      for (int steps = 0; steps < POOL && cur < POOL; steps++) begin
         in_pool = blk_size[cur] <= POOL && cur + HDR + blk_size[cur] <= POOL;
         if (in_pool && blk_size[cur] >= HDR + need) begin
            n = cur + HDR + need;
            blk_size[n] = blk_size[cur] - need - HDR;
            blk_next[n] = blk_next[cur];
            blk_last[n] = blk_last[cur];
            blk_size[cur] = need;
            link_to(has_prev, prev, n);
            ok = 1'b1;
            return cur + HDR;
         end
         if (in_pool && blk_size[cur] >= need) begin
            if (has_prev) begin
               blk_next[prev] = blk_next[cur];
               blk_last[prev] = blk_last[cur];
            end else if (blk_last[cur]) begin
               list_empty = 1'b1;
            end else begin
               list_head = blk_next[cur];
            end
            ok = 1'b1;
            return cur + HDR;
         end
         if (blk_last[cur]) break;
         has_prev = 1'b1;
         prev     = cur;
         cur      = blk_next[cur];
      end
      return 0;
   endfunction

   // Ordered insert with coalescing on both sides
   function automatic bit release_block(int unsigned off);
      int unsigned h;
      int unsigned sz;
      int unsigned cur;
      int unsigned prev;
      bit          has_prev;
      bit          has_cur;
      bit          join_prev;
      bit          join_next;
      prev     = 0;
      has_prev = 1'b0;
      if (off < HDR) return 1'b0;
      h = off - HDR;
      if (h >= POOL) return 1'b0;
      sz = blk_size[h];
      if (list_empty) begin
         blk_last[h] = 1'b1;
         list_head   = h;
         list_empty  = 1'b0;
         return 1'b1;
      end
      cur     = list_head;
      has_cur = 1'b1;
      for (int steps = 0; steps < POOL && cur < h; steps++) begin
         has_prev = 1'b1;
         prev     = cur;
         if (blk_last[cur]) begin
            has_cur = 1'b0;
            break;
         end
         cur = blk_next[cur];
      end
      if (has_cur && cur == h) return 1'b1;
      join_prev = has_prev && prev + HDR + blk_size[prev] == h;
      join_next = has_cur && h + HDR + sz == cur;
      if (join_prev && join_next) begin
         blk_size[prev] += 2 * HDR + sz + blk_size[cur];
         blk_next[prev]  = blk_next[cur];
         blk_last[prev]  = blk_last[cur];
      end else if (join_prev) begin
         blk_size[prev] += HDR + sz;
      end else if (join_next) begin
         blk_size[h] = sz + HDR + blk_size[cur];
         blk_next[h] = blk_next[cur];
         blk_last[h] = blk_last[cur];
         link_to(has_prev, prev, h);
      end else begin
         blk_next[h] = has_cur ? cur : 0;
         blk_last[h] = !has_cur;
         link_to(has_prev, prev, h);
      end
      return 1'b1;
   endfunction

   // Offer one request, wait for its transfer, then record the expected response
   task automatic send_request(logic op, int unsigned bytes, int unsigned off);
      alloc_result_type exp_res;
      bit               ok;
      int unsigned      pay;
      while (!no_idle && $urandom_range(99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, off[ffpa_pkg::OFFSET_W-1:0], bytes[ffpa_pkg::BYTES_W-1:0], op};
      do @(posedge clock); while (!req_tready);
      exp_res.payload_offset = '0;
      if (op == ffpa_pkg::OP_ALLOC) begin
         pay = first_fit(bytes, ok);
         exp_res.payload_offset = pay[ffpa_pkg::OFFSET_W-1:0];
         if (ok) live_offsets.push_back(pay);
      end else begin
         ok = release_block(off);
      end
      exp_res.success = ok;
      pending_results.push_back(exp_res);
   endtask

   task automatic free_live(int unsigned idx);
      int unsigned off;
      off = live_offsets[idx];
      live_offsets.delete(idx);
      send_request(ffpa_pkg::OP_FREE, $urandom_range(8191), off);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Extremes, empty list, out-of-range and double frees
   task automatic test_directed();
      send_request(ffpa_pkg::OP_ALLOC, POOL - HDR, 4095);
      send_request(ffpa_pkg::OP_ALLOC, 1, 0);
      send_request(ffpa_pkg::OP_FREE, 0, HDR);
      send_request(ffpa_pkg::OP_FREE, 8191, HDR);
      live_offsets.delete();
      send_request(ffpa_pkg::OP_ALLOC, POOL - HDR + 1, 0);
      send_request(ffpa_pkg::OP_ALLOC, 8191, 4095);
      send_request(ffpa_pkg::OP_ALLOC, 4096, 0);
      send_request(ffpa_pkg::OP_ALLOC, 0, 0);
      send_request(ffpa_pkg::OP_ALLOC, 0, 0);
      send_request(ffpa_pkg::OP_ALLOC, 7, 0);
      send_request(ffpa_pkg::OP_ALLOC, 8, 0);
      send_request(ffpa_pkg::OP_ALLOC, 9, 0);
      send_request(ffpa_pkg::OP_ALLOC, 100, 0);
      send_request(ffpa_pkg::OP_FREE, 0, 0);
      send_request(ffpa_pkg::OP_FREE, 0, HDR - 1);
      free_live(1);
      free_live(2);
      free_live(1);
      free_live(live_offsets.size() - 1);
      send_request(ffpa_pkg::OP_FREE, 0, list_head + HDR);
      send_request(ffpa_pkg::OP_ALLOC, 3000, 0);
      send_request(ffpa_pkg::OP_ALLOC, 4000, 0);
      while (live_offsets.size() != 0) free_live(0);
   endtask

   // Mostly valid alloc/free sequences, some noise
   task automatic test_random(int unsigned count);
      int unsigned pick;
      int unsigned bytes;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_request(ffpa_pkg::OP_FREE, $urandom_range(8191),
                         list_empty ? $urandom_range(HDR - 1) : list_head + HDR);
         end else if (pick < 8) begin
            send_request(ffpa_pkg::OP_FREE, $urandom_range(8191), $urandom_range(HDR - 1));
         end else if (pick < 55 || live_offsets.size() == 0) begin
            if ($urandom_range(19) == 0) bytes = $urandom_range(8191);
            else if ($urandom_range(4) == 0) bytes = $urandom_range(1024);
            else bytes = $urandom_range(160);
            send_request(ffpa_pkg::OP_ALLOC, bytes, $urandom_range(4095));
         end else begin
            free_live($urandom_range(live_offsets.size() - 1));
         end
      end
   endtask

   // Stop the receiver while requests keep coming
   task automatic test_backpressure();
      hold_off_request = 400;
      test_random(40);
   endtask

   task automatic test_no_idle();
      no_idle = 1'b1;
      test_random(150);
      no_idle = 1'b0;
   endtask

   // Free of a header that was never written as a block
   task automatic test_unwritten_free();
      send_request(ffpa_pkg::OP_FREE, 0, 4095);
      send_request(ffpa_pkg::OP_ALLOC, 0, 0);
   endtask

   // Receiver: random stalls and one long hold-off
   always @(posedge clock) begin
      if (hold_off_request != 0 && quiet_cycles == 0) begin
         quiet_cycles     <= hold_off_request;
         hold_off_request <= 0;
         rsp_tready       <= 1'b0;
      end else if (quiet_cycles != 0) begin
         quiet_cycles <= quiet_cycles - 1;
         rsp_tready   <= (quiet_cycles == 1);
      end else begin
         rsp_tready <= no_idle || $urandom_range(99) >= STALL_PCT;
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      alloc_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tdata[11:0] !== exp_res.payload_offset) begin
               $error("payload_offset expected %0d actual %0d",
                      exp_res.payload_offset, rsp_tdata[11:0]);
               error_count++;
            end
            if (rsp_tdata[12] !== exp_res.success) begin
               $error("success expected %0d actual %0d", exp_res.success, rsp_tdata[12]);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         accept_count <= 0;
      end else if (accept_count >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         accept_count <= accept_count + 1;
      end
   end

   initial begin
      pool_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(RANDOM_ITEMS);
      test_backpressure();
      test_no_idle();
      test_unwritten_free();
      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
